// ===== rtl/core/quorum_vote_tracker_unit_assert.svh =====
// Assertion macros shared by the quorum vote tracker RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef QUORUM_VOTE_TRACKER_UNIT_ASSERT_SVH
`define QUORUM_VOTE_TRACKER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// clocked check, switched off while reset is held
`define QVT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("quorum vote tracker: assertion failed");

// same, with a message of the caller's own
`define QVT_ASSERT_MSG(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`else

`define QVT_ASSERT(label, clk, rst_n, prop)
`define QVT_ASSERT_MSG(label, clk, rst_n, prop, msg)

`endif

`endif

// ===== rtl/core/qvt_pkg.sv =====
// Shared types and constants for the quorum vote tracker.
// No dependencies; used by qvt_slot_ram, qvt_update and the top level.
package qvt_pkg;

    // slot table geometry (SLOTS must be a power of two)
    localparam int SLOTS  = 1024;
    localparam int SLOT_W = $clog2(SLOTS);

    localparam int VIEW_W  = 32;
    localparam int OPNUM_W = 32;
    localparam int VOTES_W = 32;
    localparam int REP_W   = 6;
    localparam int COUNT_W = 6;
    localparam int THR_W   = 6;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(2);

    // request kinds
    localparam logic REQ_OPEN = 1'b0;
    localparam logic REQ_VOTE = 1'b1;

    // verdict codes
    localparam logic [1:0] VERDICT_PASS   = 2'd0;
    localparam logic [1:0] VERDICT_DROP   = 2'd1;
    localparam logic [1:0] VERDICT_QUORUM = 2'd2;
    localparam logic [1:0] VERDICT_OPEN   = 2'd3;

    typedef struct packed {
        logic [VIEW_W-1:0]  view;
        logic [OPNUM_W-1:0] opnum;
        logic [VOTES_W-1:0] votes;
    } t_slot;

    typedef struct packed {
        logic               req_type;
        logic [VIEW_W-1:0]  view;
        logic [OPNUM_W-1:0] opnum;
        logic [REP_W-1:0]   replica_idx;
    } t_item;

    typedef struct packed {
        logic               wr_en;
        t_slot              entry;
        logic [1:0]         verdict;
        logic [COUNT_W-1:0] count;
    } t_upd;

endpackage

// ===== rtl/core/qvt_slot_ram.sv =====
// Slot table: one-read one-write synchronous memory with a clearing sweep after reset.
// Depends on qvt_pkg and quorum_vote_tracker_unit_assert.svh.
`include "quorum_vote_tracker_unit_assert.svh"

module qvt_slot_ram (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    input  logic [qvt_pkg::SLOT_W-1:0] i_rd_addr,
    output qvt_pkg::t_slot             o_rd_data,
    input  logic                       i_wr_en,
    input  logic [qvt_pkg::SLOT_W-1:0] i_wr_addr,
    input  qvt_pkg::t_slot             i_wr_data,
    output logic                       o_clearing
);

    localparam logic [qvt_pkg::SLOT_W-1:0] LAST_IDX = qvt_pkg::SLOT_W'(qvt_pkg::SLOTS - 1);

    qvt_pkg::t_slot                 mem [qvt_pkg::SLOTS];
    qvt_pkg::t_slot                 r_rd_data;
    logic                           r_clr_busy;
    logic                           n_clr_busy;
    logic [qvt_pkg::SLOT_W-1:0]     r_clr_idx;
    logic [qvt_pkg::SLOT_W-1:0]     n_clr_idx;
    logic                           wr_en;
    logic [qvt_pkg::SLOT_W-1:0]     wr_addr;
    qvt_pkg::t_slot                 wr_data;

    // clearing sweep: one entry per cycle after reset
    always_comb begin
        n_clr_busy = r_clr_busy;
        n_clr_idx  = r_clr_idx;
        if (r_clr_busy) begin
            n_clr_idx = r_clr_idx + qvt_pkg::SLOT_W'(1);
            if (r_clr_idx == LAST_IDX) begin
                n_clr_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else begin
            r_clr_busy <= n_clr_busy;
            r_clr_idx  <= n_clr_idx;
        end
    end

    // write port: sweep has priority, user writes never overlap it
    always_comb begin
        wr_en   = r_clr_busy | i_wr_en;
        wr_addr = r_clr_busy ? r_clr_idx : i_wr_addr;
        wr_data = r_clr_busy ? '0 : i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clr_busy;

    `QVT_ASSERT(a_no_access_in_clear, i_clk, i_rst_n, r_clr_busy |-> !i_wr_en && !i_rd_en)
    `QVT_ASSERT(a_clear_ends, i_clk, i_rst_n, r_clr_busy && r_clr_idx == LAST_IDX |=> !r_clr_busy)

endmodule

// ===== rtl/core/qvt_update.sv =====
// Slot update: tag match, voter bit set, popcount and verdict for one word.
// Depends on qvt_pkg.
module qvt_update (
    input  qvt_pkg::t_item             i_item,
    input  qvt_pkg::t_slot             i_slot,
    input  logic [qvt_pkg::THR_W-1:0]  i_threshold,
    output qvt_pkg::t_upd              o_upd
);

    // population count as an adder tree
    function automatic logic [qvt_pkg::COUNT_W-1:0] popcount32(
        input logic [qvt_pkg::VOTES_W-1:0] x
    );
        logic [1:0] s1 [16];
        logic [2:0] s2 [8];
        logic [3:0] s3 [4];
        logic [4:0] s4 [2];
        for (int i = 0; i < 16; i++) s1[i] = {1'b0, x[2*i]} + {1'b0, x[2*i+1]};
        for (int i = 0; i < 8; i++)  s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
        for (int i = 0; i < 4; i++)  s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
        for (int i = 0; i < 2; i++)  s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
        return {1'b0, s4[0]} + {1'b0, s4[1]};
    endfunction

    logic                              match;
    logic [qvt_pkg::VOTES_W-1:0]       voter_bit;
    logic [qvt_pkg::VOTES_W-1:0]       new_votes;
    logic [qvt_pkg::COUNT_W-1:0]       old_count;
    logic [qvt_pkg::COUNT_W-1:0]       new_count;

    // voter bit only for replica indices below 32
    always_comb begin
        match     = (i_slot.view == i_item.view) && (i_slot.opnum == i_item.opnum);
        voter_bit = i_item.replica_idx[qvt_pkg::REP_W-1] ? '0
                  : qvt_pkg::VOTES_W'(1) << i_item.replica_idx[qvt_pkg::REP_W-2:0];
        new_votes = i_slot.votes | voter_bit;
        old_count = popcount32(i_slot.votes);
        new_count = popcount32(new_votes);
    end

    // verdict and write-back
    always_comb begin
        o_upd = '0;
        if (i_item.req_type == qvt_pkg::REQ_OPEN) begin
            o_upd.wr_en       = 1'b1;
            o_upd.entry.view  = i_item.view;
            o_upd.entry.opnum = i_item.opnum;
            o_upd.entry.votes = '0;
            o_upd.verdict     = qvt_pkg::VERDICT_OPEN;
            o_upd.count       = '0;
        end else if (!match) begin
            o_upd.wr_en   = 1'b0;
            o_upd.entry   = i_slot;
            o_upd.verdict = qvt_pkg::VERDICT_PASS;
            o_upd.count   = old_count;
        end else begin
            o_upd.wr_en       = 1'b1;
            o_upd.entry.view  = i_slot.view;
            o_upd.entry.opnum = i_slot.opnum;
            o_upd.entry.votes = new_votes;
            o_upd.verdict     = (new_count == i_threshold) ? qvt_pkg::VERDICT_QUORUM
                                                           : qvt_pkg::VERDICT_DROP;
            o_upd.count       = new_count;
        end
    end

endmodule

// ===== rtl/core/quorum_vote_tracker_unit.sv =====
// Quorum vote tracker: one result word per input word.
// The block first reads the slot memory, then updates it and loads the output register
// once that register is free; no new word is taken until the update is done.
// A new word is taken while a result waits.
// Reset (synchronous, active low) sets threshold to 2 and sweeps the 1024-slot table
// to zero, during which no word is accepted.
`include "quorum_vote_tracker_unit_assert.svh"

module quorum_vote_tracker_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [qvt_pkg::THR_W-1:0]   i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_req_type,
    input  logic [qvt_pkg::VIEW_W-1:0]  i_view,
    input  logic [qvt_pkg::OPNUM_W-1:0] i_opnum,
    input  logic [qvt_pkg::REP_W-1:0]   i_replica_idx,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_verdict,
    output logic [qvt_pkg::COUNT_W-1:0] o_vote_count
);

    logic [qvt_pkg::THR_W-1:0]   r_threshold;
    logic                        r_busy;
    logic                        n_busy;
    qvt_pkg::t_item              r_item;
    logic                        r_out_valid;
    logic                        n_out_valid;
    logic [1:0]                  r_verdict;
    logic [qvt_pkg::COUNT_W-1:0] r_vote_count;
    logic                        clearing;
    logic                        in_fire;
    logic                        finish;
    logic [qvt_pkg::SLOT_W-1:0]  in_slot;
    logic [qvt_pkg::SLOT_W-1:0]  cur_slot;
    qvt_pkg::t_slot              rd_data;
    qvt_pkg::t_upd               upd;
    logic                        out_open;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= qvt_pkg::THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_wdata;
        end
    end

    // handshake and sequencing
    always_comb begin
        o_in_ready  = !r_busy && !clearing;
        in_fire     = i_in_valid && o_in_ready;
        finish      = r_busy && (!r_out_valid || i_out_ready);
        in_slot     = i_opnum[qvt_pkg::SLOT_W-1:0];
        cur_slot    = r_item.opnum[qvt_pkg::SLOT_W-1:0];
        n_busy      = in_fire ? 1'b1 : (finish ? 1'b0 : r_busy);
        n_out_valid = finish ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    // captured input word
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item.req_type    <= i_req_type;
            r_item.view        <= i_view;
            r_item.opnum       <= i_opnum;
            r_item.replica_idx <= i_replica_idx;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_verdict    <= upd.verdict;
            r_vote_count <= upd.count;
        end
    end

    qvt_slot_ram u_slot_ram (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (in_fire),
        .i_rd_addr  (in_slot),
        .o_rd_data  (rd_data),
        .i_wr_en    (finish && upd.wr_en),
        .i_wr_addr  (cur_slot),
        .i_wr_data  (upd.entry),
        .o_clearing (clearing)
    );

    qvt_update u_update (
        .i_item      (r_item),
        .i_slot      (rd_data),
        .i_threshold (r_threshold),
        .o_upd       (upd)
    );

    assign o_out_valid  = r_out_valid;
    assign o_verdict    = r_verdict;
    assign o_vote_count = r_vote_count;

    // an open word waiting at the output
    assign out_open = r_out_valid && (r_verdict == qvt_pkg::VERDICT_OPEN);

    `QVT_ASSERT(a_accept_starts_work, i_clk, i_rst_n, in_fire |=> r_busy)
    `QVT_ASSERT(a_finish_loads_out, i_clk, i_rst_n, finish |=> r_out_valid && !r_busy)
    `QVT_ASSERT(a_open_count_zero, i_clk, i_rst_n, out_open |-> r_vote_count == '0)

endmodule

// ===== verif/quorum_vote_tracker_unit_tb.sv =====
// Self-checking testbench for quorum_vote_tracker_unit: a ledger class keeps its own
// copy of the slot table, predicts verdict and vote count per word and checks results.
// Depends on qvt_pkg and the quorum_vote_tracker_unit RTL.

// Slot table mirror and queue of verdicts still to come out of the block
class quorum_ledger;

    typedef struct packed {
        logic [1:0]                  verdict;
        logic [qvt_pkg::COUNT_W-1:0] count;
    } t_verdict;

    logic [qvt_pkg::VIEW_W-1:0]  view_tbl  [qvt_pkg::SLOTS];
    logic [qvt_pkg::OPNUM_W-1:0] opnum_tbl [qvt_pkg::SLOTS];
    logic [qvt_pkg::VOTES_W-1:0] votes_tbl [qvt_pkg::SLOTS];
    logic [qvt_pkg::THR_W-1:0]   threshold;
    t_verdict                    verdicts_due [$];
    int unsigned                 errors;

    // state after reset: empty table, default threshold
    function new();
        foreach (view_tbl[i]) begin
            view_tbl[i]  = '0;
            opnum_tbl[i] = '0;
            votes_tbl[i] = '0;
        end
        threshold = qvt_pkg::THRESHOLD_RESET;
        errors    = 0;
    endfunction

    function void set_threshold(input logic [qvt_pkg::THR_W-1:0] value);
        threshold = value;
    endfunction

    function int outstanding();
        return verdicts_due.size();
    endfunction

    // apply one accepted word to the mirror and queue its verdict
    function void note_word(input logic                        kind,
                            input logic [qvt_pkg::VIEW_W-1:0]  view,
                            input logic [qvt_pkg::OPNUM_W-1:0] opnum,
                            input logic [qvt_pkg::REP_W-1:0]   rep);
        logic [qvt_pkg::SLOT_W-1:0] idx;
        t_verdict                   res;
        idx = opnum[qvt_pkg::SLOT_W-1:0];
        if (kind == qvt_pkg::REQ_OPEN) begin
            view_tbl[idx]  = view;
            opnum_tbl[idx] = opnum;
            votes_tbl[idx] = '0;
            res.verdict    = qvt_pkg::VERDICT_OPEN;
            res.count      = '0;
        end else if (view_tbl[idx] != view || opnum_tbl[idx] != opnum) begin
            // stale or foreign vote: slot untouched
            res.verdict = qvt_pkg::VERDICT_PASS;
            res.count   = qvt_pkg::COUNT_W'($countones(votes_tbl[idx]));
        end else begin
            // replicas at 32 and above carry no bit and add nothing to the count
            if (rep < 32)
                votes_tbl[idx][rep[4:0]] = 1'b1;
            res.count   = qvt_pkg::COUNT_W'($countones(votes_tbl[idx]));
            res.verdict = (res.count == threshold) ? qvt_pkg::VERDICT_QUORUM
                                                   : qvt_pkg::VERDICT_DROP;
        end
        verdicts_due.push_back(res);
    endfunction

    // compare one result word against the oldest prediction
    function void check_result(input logic [1:0]                  verdict,
                               input logic [qvt_pkg::COUNT_W-1:0] count);
        t_verdict exp_r;
        if (verdicts_due.size() == 0) begin
            $error("unexpected result word: verdict %0d vote_count %0d", verdict, count);
            errors++;
            return;
        end
        exp_r = verdicts_due.pop_front();
        if (verdict !== exp_r.verdict) begin
            $error("verdict: expected %0d, actual %0d", exp_r.verdict, verdict);
            errors++;
        end
        if (count !== exp_r.count) begin
            $error("vote_count: expected %0d, actual %0d", exp_r.count, count);
            errors++;
        end
    endfunction

endclass

module quorum_vote_tracker_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_WORDS    = 1400;
    localparam int PHASE_WORDS    = 175;
    localparam int SETTLE_CYCLES  = 6;     // settle margin after the last result
    localparam int WATCHDOG_LIMIT = 6000;  // covers the table sweep after reset

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        i_cfg_we      = 1'b0;
    logic [qvt_pkg::THR_W-1:0]   i_cfg_wdata   = '0;
    logic                        i_in_valid    = 1'b0;
    logic                        o_in_ready;
    logic                        i_req_type    = qvt_pkg::REQ_OPEN;
    logic [qvt_pkg::VIEW_W-1:0]  i_view        = '0;
    logic [qvt_pkg::OPNUM_W-1:0] i_opnum       = '0;
    logic [qvt_pkg::REP_W-1:0]   i_replica_idx = '0;
    logic                        o_out_valid;
    logic                        i_out_ready   = 1'b0;
    logic [1:0]                  o_verdict;
    logic [qvt_pkg::COUNT_W-1:0] o_vote_count;

    quorum_ledger ledger;
    int unsigned  words_taken   = 0;
    int unsigned  send_idle_pct = 0;
    int unsigned  stall_pct     = 0;
    int unsigned  quiet_cycles  = 0;
    logic [qvt_pkg::SLOT_W-1:0] hot_slots [8];

    quorum_vote_tracker_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_view        (i_view),
        .i_opnum       (i_opnum),
        .i_replica_idx (i_replica_idx),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_verdict     (o_verdict),
        .o_vote_count  (o_vote_count)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            ledger.check_result(o_verdict, o_vote_count);
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT - 1) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one word, with random idle cycles ahead of it, and wait for acceptance
    task automatic send_word(input logic                        kind,
                             input logic [qvt_pkg::VIEW_W-1:0]  view,
                             input logic [qvt_pkg::OPNUM_W-1:0] opnum,
                             input logic [qvt_pkg::REP_W-1:0]   rep);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0) begin
            // idle payload is junk on purpose
            i_in_valid    <= 1'b0;
            i_req_type    <= 1'($urandom);
            i_view        <= $urandom;
            i_opnum       <= $urandom;
            i_replica_idx <= qvt_pkg::REP_W'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_req_type    <= kind;
        i_view        <= view;
        i_opnum       <= opnum;
        i_replica_idx <= rep;
        do
            @(posedge i_clk);
        while (!(i_in_valid && o_in_ready));
        ledger.note_word(kind, view, opnum, rep);
        words_taken++;
    endtask

    // hold the sender off until every result is out and the pipeline is quiet
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (ledger.outstanding() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [qvt_pkg::THR_W-1:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        ledger.set_threshold(value);
    endtask

    // open a slot, then a run of votes on it mixed with stale votes and noise
    task automatic run_ballot();
        logic [qvt_pkg::VIEW_W-1:0]  view;
        logic [qvt_pkg::OPNUM_W-1:0] opnum;
        logic [qvt_pkg::REP_W-1:0]   order [32];
        logic [qvt_pkg::REP_W-1:0]   tmp;
        logic [qvt_pkg::REP_W-1:0]   rep;
        bit                          sweep;
        int                          n;
        int                          k;
        int                          pick;

        case ($urandom_range(7))
            0:       view = '0;
            1:       view = '1;
            default: view = $urandom;
        endcase
        opnum = $urandom;
        if ($urandom_range(7) != 0)
            opnum[qvt_pkg::SLOT_W-1:0] = hot_slots[$urandom_range(7)];
        send_word(qvt_pkg::REQ_OPEN, view, opnum, qvt_pkg::REP_W'($urandom));

        // a sweep votes every replica below 32 once in shuffled order, enough to reach 32
        sweep = ($urandom_range(3) == 0);
        for (int i = 0; i < 32; i++)
            order[i] = qvt_pkg::REP_W'(i);
        for (int i = 31; i > 0; i--) begin
            k        = $urandom_range(i);
            tmp      = order[i];
            order[i] = order[k];
            order[k] = tmp;
        end
        n = sweep ? 32 : $urandom_range(1, 12);

        for (int i = 0; i < n; i++) begin
            if (sweep)
                rep = order[i];
            else if ($urandom_range(3) == 0)
                rep = qvt_pkg::REP_W'($urandom);
            else
                rep = qvt_pkg::REP_W'($urandom_range(7));
            pick = $urandom_range(9);
            if (pick == 0)
                send_word(qvt_pkg::REQ_VOTE, view ^ (32'd1 << $urandom_range(31)),
                          opnum, rep);
            else if (pick == 1)
                send_word(qvt_pkg::REQ_VOTE, view,
                          opnum ^ (32'd1 << $urandom_range(31, qvt_pkg::SLOT_W)), rep);
            else if (pick == 2)
                send_word(1'($urandom), $urandom, $urandom, qvt_pkg::REP_W'($urandom));
            if (pick != 2 || sweep)
                send_word(qvt_pkg::REQ_VOTE, view, opnum, rep);
        end
    endtask

    // stimulus
    initial begin
        int unsigned               idle_profile  [4];
        int unsigned               stall_profile [4];
        logic [qvt_pkg::THR_W-1:0] thr_sweep     [5];
        logic [qvt_pkg::THR_W-1:0] thr;
        int unsigned               target;

        idle_profile  = '{0, 53, 0, 35};
        stall_profile = '{0, 0, 53, 35};
        thr_sweep     = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd2};
        foreach (hot_slots[i])
            hot_slots[i] = qvt_pkg::SLOT_W'($urandom);
        hot_slots[0] = '0;
        hot_slots[1] = '1;

        ledger = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: untouched slot 0 matches view 0 / opnum 0, default threshold 2
        send_idle_pct = 35;
        stall_pct     = 35;
        send_word(qvt_pkg::REQ_VOTE, 32'h0, 32'h0, 6'd0);
        send_word(qvt_pkg::REQ_VOTE, 32'h0, 32'h0, 6'd40);   // high replica, no bit
        send_word(qvt_pkg::REQ_VOTE, 32'h0, 32'h400, 6'd1);  // same slot, other opnum
        send_word(qvt_pkg::REQ_VOTE, 32'h0, 32'h0, 6'd31);   // reaches quorum
        send_word(qvt_pkg::REQ_VOTE, 32'h0, 32'h0, 6'd31);   // repeat signals again
        send_word(qvt_pkg::REQ_VOTE, 32'h0, 32'h0, 6'd63);
        send_word(qvt_pkg::REQ_VOTE, 32'h0, 32'h6, 6'd2);    // never-opened slot
        // top slot with all-ones fields
        send_word(qvt_pkg::REQ_OPEN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
        send_word(qvt_pkg::REQ_VOTE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0);
        send_word(qvt_pkg::REQ_VOTE, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 6'd5);
        send_word(qvt_pkg::REQ_VOTE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 6'd5);
        send_word(qvt_pkg::REQ_VOTE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd32);
        send_word(qvt_pkg::REQ_VOTE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd1);
        send_word(qvt_pkg::REQ_VOTE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd2);
        // reopen clears the votes
        send_word(qvt_pkg::REQ_OPEN, 32'h1234_5678, 32'hFFFF_FFFF, 6'd0);
        send_word(qvt_pkg::REQ_VOTE, 32'h1234_5678, 32'hFFFF_FFFF, 6'd17);
        send_word(qvt_pkg::REQ_OPEN, 32'h0, 32'h0, 6'd0);
        send_word(qvt_pkg::REQ_VOTE, 32'h0, 32'h0, 6'd33);

        // random phases, each with its own threshold and idling profile
        for (int phase = 0; words_taken < TOTAL_WORDS; phase++) begin
            thr = (phase < 5) ? thr_sweep[phase]
                              : qvt_pkg::THR_W'($urandom_range(1, 32));
            write_threshold(thr);
            send_idle_pct = idle_profile[phase % 4];
            stall_pct     = stall_profile[phase % 4];
            target        = words_taken + PHASE_WORDS;
            while (words_taken < target) begin
                run_ballot();
                if ($urandom_range(9) == 0)
                    drain_results();
            end
        end

        // wind down
        drain_results();
        if (ledger.outstanding() != 0) begin
            $error("%0d verdicts never arrived", ledger.outstanding());
            ledger.errors++;
        end
        if (ledger.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
